/* design/qte_pkg.sv */
// Shared types, constants and helper functions for the quaternion to Euler angle converter.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

	// Default number of CORDIC vectoring cells
	localparam int CORDIC_STAGES_DEF = 16;

	// Datapath widths
	localparam int IW       = 18;            // quaternion component, Q1.16
	localparam int PW       = 36;            // exact component product
	localparam int SW       = 38;            // sum of products
	localparam int CW       = 40;            // CORDIC x/y lane
	localparam int ZW       = 26;            // CORDIC angle, 2^-16 degree
	localparam int TW       = 17;            // lock threshold register
	localparam int SVW      = 22;            // sine term
	localparam int SQ_STEPS = 25;            // root bits of floor sqrt
	localparam int SQ_VW    = 2 * SQ_STEPS;  // radicand
	localparam int SQ_RW    = SQ_STEPS + 3;  // partial remainder
	localparam int AW       = 18;            // rounded output angle

	localparam logic [TW-1:0]        THR_RESET = 17'd65529;
	localparam logic signed [ZW-1:0] Z_P90     = 26'sd5898240;
	localparam logic signed [ZW-1:0] Z_M90     = -26'sd5898240;
	localparam logic signed [ZW-1:0] HEAD_LIM  = 26'sd46080;
	localparam logic signed [ZW-1:0] ELEV_LIM  = 26'sd23040;

	// One CORDIC lane word
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} lane_t;

	// One digit-by-digit square root word
	typedef struct packed {
		logic [SQ_RW-1:0]    r;
		logic [SQ_STEPS-1:0] q;
		logic [SQ_VW-1:0]    v;
	} sqrt_t;

	// Data riding alongside the square root chain
	typedef struct packed {
		logic                 lock;
		logic signed [15:0]   elev_lock;
		logic signed [25:0]   ya;
		logic signed [SW-1:0] yb;
		logic signed [SW-1:0] xb;
		logic signed [SW-1:0] yc;
		logic signed [SW-1:0] xc;
	} side_t;

	// Data riding alongside the CORDIC chain
	typedef struct packed {
		logic               lock;
		logic signed [15:0] elev_lock;
	} tag_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0:  a = 26'sd2949120;
			1:  a = 26'sd1740967;
			2:  a = 26'sd919879;
			3:  a = 26'sd466945;
			4:  a = 26'sd234379;
			5:  a = 26'sd117304;
			6:  a = 26'sd58666;
			7:  a = 26'sd29335;
			8:  a = 26'sd14668;
			9:  a = 26'sd7334;
			10: a = 26'sd3667;
			11: a = 26'sd1833;
			12: a = 26'sd917;
			13: a = 26'sd458;
			14: a = 26'sd229;
			15: a = 26'sd115;
			16: a = 26'sd57;
			17: a = 26'sd29;
			18: a = 26'sd14;
			19: a = 26'sd7;
			20: a = 26'sd4;
			21: a = 26'sd2;
			22: a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

	// Quadrant fold into the right half plane, zero vector flagged
	function automatic lane_t prerot(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		lane_t o;
		o.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			if (y >= 0) begin
				o.x = y;
				o.y = -x;
				o.z = Z_P90;
			end else begin
				o.x = -y;
				o.y = x;
				o.z = Z_M90;
			end
		end else begin
			o.x = x;
			o.y = y;
			o.z = '0;
		end
		return o;
	endfunction

	// Round half away from zero to 1/256 degree, then saturate
	function automatic logic signed [AW-1:0] out_angle(input logic signed [ZW-1:0] z,
			input logic signed [ZW-1:0] lim);
		logic signed [ZW-1:0] r;
		if (z >= 0) begin
			r = (z + 26'sd128) >>> 8;
		end else begin
			r = -((-z + 26'sd128) >>> 8);
		end
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[AW-1:0];
	endfunction

endpackage
`default_nettype wire

/* design/qte_sqrt_cell.sv */
// One cell of the floor square root chain: one root bit per cell.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qte_pkg::sqrt_t sq_i,
	output qte_pkg::sqrt_t     sq_o
);

	logic [qte_pkg::SQ_RW-1:0] r_sh;
	logic [qte_pkg::SQ_RW-1:0] trial;
	logic                      ge;
	qte_pkg::sqrt_t            nxt;
	qte_pkg::sqrt_t            sq_q;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		r_sh  = {sq_i.r[qte_pkg::SQ_RW-3:0], sq_i.v[qte_pkg::SQ_VW-1 -: 2]};
		trial = {1'b0, sq_i.q, 2'b01};
		ge    = r_sh >= trial;
		nxt.r = ge ? (r_sh - trial) : r_sh;
		nxt.q = {sq_i.q[qte_pkg::SQ_STEPS-2:0], ge};
		nxt.v = {sq_i.v[qte_pkg::SQ_VW-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= nxt;
		end
	end

	assign sq_o = sq_q;

endmodule
`default_nettype wire

/* design/qte_cordic_cell.sv */
// One CORDIC vectoring cell: one micro-rotation by atan(2^-STAGE).
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire qte_pkg::lane_t lane_i,
	output qte_pkg::lane_t      lane_o
);

	localparam logic signed [qte_pkg::ZW-1:0] ATAN = qte_pkg::atan_tab(STAGE);

	logic signed [qte_pkg::CW-1:0] dx;
	logic signed [qte_pkg::CW-1:0] dy;
	qte_pkg::lane_t                nxt;
	qte_pkg::lane_t                lane_q;

	// drive y toward zero
	always_comb begin
		dx       = lane_i.y >>> STAGE;
		dy       = lane_i.x >>> STAGE;
		nxt.zero = lane_i.zero;
		if (lane_i.y > 0) begin
			nxt.x = lane_i.x + dx;
			nxt.y = lane_i.y - dy;
			nxt.z = lane_i.z + ATAN;
		end else begin
			nxt.x = lane_i.x - dx;
			nxt.y = lane_i.y + dy;
			nxt.z = lane_i.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

	assign lane_o = lane_q;

endmodule
`default_nettype wire

/* design/quaternion_to_euler_angles_top.sv */
// Quaternion to Euler angle converter: products, sine term, sqrt chain, three CORDIC lanes.
// Depends on qte_pkg, qte_sqrt_cell and qte_cordic_cell.
// Registers in order: products, sine term, radicand, the 25 root cells, the quadrant fold,
// the CORDIC cells and the output. Throughput: one word per cycle; a stalled output word
// halts the whole pipeline. Reset clears the valid bits and loads lock_threshold = 65529.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [qte_pkg::TW-1:0]         cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [qte_pkg::IW-1:0]  qx,
	input  wire logic signed [qte_pkg::IW-1:0]  qy,
	input  wire logic signed [qte_pkg::IW-1:0]  qz,
	input  wire logic signed [qte_pkg::IW-1:0]  qw,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [16:0]                  heading_angle,
	output logic signed [15:0]                  elevation_angle,
	output logic signed [16:0]                  bank_angle,
	output logic                                gimbal_lock
);

	localparam int SQ  = qte_pkg::SQ_STEPS;
	localparam int LAT = 3 + SQ + 1 + CORDIC_STAGES + 1;
	localparam int SW  = qte_pkg::SW;
	localparam int CW  = qte_pkg::CW;
	localparam logic signed [SW-1:0] HALF = 38'sd2147483648;

	logic                 adv;
	logic                 in_acc;
	logic [LAT-1:0]       vld_q;
	logic [qte_pkg::TW-1:0] thr_q;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qte_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// global advance; output register holds while stalled
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_acc};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// stage 1: component products
	logic signed [qte_pkg::PW-1:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1;
	logic signed [qte_pkg::PW-1:0] pyz_s1, pwx_s1, pwy_s1, pwz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s1 <= qx * qx;
			pyy_s1 <= qy * qy;
			pzz_s1 <= qz * qz;
			pxy_s1 <= qx * qy;
			pxz_s1 <= qx * qz;
			pyz_s1 <= qy * qz;
			pwx_s1 <= qw * qx;
			pwy_s1 <= qw * qy;
			pwz_s1 <= qw * qz;
		end
	end

	// stage 2: sine term, lock decision, atan2 vectors
	logic signed [SW-1:0]             sum_s;
	logic [SW-1:0]                    mag_s;
	logic [SW-1:0]                    rnd_s;
	logic signed [qte_pkg::SVW-1:0]   s_val;
	logic signed [17:0]               sc_val;
	logic                             lock_c;
	logic signed [SW-1:0]             xx, yy, zz, xy, xz, wy, wz;

	always_comb begin
		xx    = SW'(pxx_s1);
		yy    = SW'(pyy_s1);
		zz    = SW'(pzz_s1);
		xy    = SW'(pxy_s1);
		xz    = SW'(pxz_s1);
		wy    = SW'(pwy_s1);
		wz    = SW'(pwz_s1);
		sum_s = SW'(pyz_s1) + SW'(pwx_s1);
		mag_s = (sum_s >= 0) ? sum_s : -sum_s;
		rnd_s = (mag_s + SW'(16384)) >> 15;
		s_val = (sum_s >= 0) ? -signed'(rnd_s[qte_pkg::SVW-1:0])
			: signed'(rnd_s[qte_pkg::SVW-1:0]);
		lock_c = rnd_s[qte_pkg::SVW-1:0] > qte_pkg::SVW'(thr_q);
		if (s_val > 22'sd65536) begin
			sc_val = 18'sd65536;
		end else if (s_val < -22'sd65536) begin
			sc_val = -18'sd65536;
		end else begin
			sc_val = s_val[17:0];
		end
	end

	logic signed [qte_pkg::SVW-1:0] s_s2;
	logic signed [17:0]             sc_s2;
	logic                           lock_s2;
	logic signed [SW-1:0]           yb_s2, xb_s2, yc_s2, xc_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2    <= s_val;
			sc_s2   <= sc_val;
			lock_s2 <= lock_c;
			yb_s2   <= lock_c ? (-xz - wy) : (xz - wy);
			xb_s2   <= lock_c ? (HALF - yy - zz) : (HALF - xx - yy);
			yc_s2   <= xy - wz;
			xc_s2   <= HALF - xx - zz;
		end
	end

	// stage 3: sqrt radicand and lock pitch
	logic signed [35:0] sq_sc;
	logic [32:0]        rem;
	logic signed [28:0] m90;
	logic [28:0]        m90_mag;
	logic [28:0]        m90_rnd;
	logic [15:0]        el_mag;
	qte_pkg::sqrt_t     sqrt_in;
	qte_pkg::side_t     side_in;

	always_comb begin
		sq_sc   = sc_s2 * sc_s2;
		rem     = 33'h1_0000_0000 - sq_sc[32:0];
		m90     = 29'(s_s2) * 29'sd90;
		m90_mag = (m90 >= 0) ? m90 : -m90;
		m90_rnd = (m90_mag + 29'd128) >> 8;
		el_mag  = (m90_rnd > 29'd23040) ? 16'd23040 : m90_rnd[15:0];
		sqrt_in.r = '0;
		sqrt_in.q = '0;
		sqrt_in.v = {1'b0, rem, 16'b0};
		side_in.lock      = lock_s2;
		side_in.elev_lock = (m90 >= 0) ? -signed'(el_mag) : signed'(el_mag);
		side_in.ya        = 26'(sc_s2) <<< 8;
		side_in.yb        = yb_s2;
		side_in.xb        = xb_s2;
		side_in.yc        = yc_s2;
		side_in.xc        = xc_s2;
	end

	qte_pkg::sqrt_t sqrt_s3;
	qte_pkg::side_t side_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			sqrt_s3 <= sqrt_in;
			side_s3 <= side_in;
		end
	end

	// square root chain with its side data
	qte_pkg::sqrt_t sq_chain [SQ];
	qte_pkg::side_t side_q   [SQ];

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			qte_sqrt_cell u_cell (.clk(clk), .en(adv), .sq_i(sqrt_s3), .sq_o(sq_chain[k]));
			always_ff @(posedge clk) begin
				if (adv) begin
					side_q[k] <= side_s3;
				end
			end
		end else begin : g_rest
			qte_sqrt_cell u_cell (.clk(clk), .en(adv), .sq_i(sq_chain[k-1]),
				.sq_o(sq_chain[k]));
			always_ff @(posedge clk) begin
				if (adv) begin
					side_q[k] <= side_q[k-1];
				end
			end
		end
	end

	// quadrant fold stage
	qte_pkg::side_t   side_end;
	logic signed [CW-1:0] c_root;
	qte_pkg::lane_t   pa_q, pb_q, pc_q;
	qte_pkg::tag_t    ptag_q;

	assign side_end = side_q[SQ-1];
	assign c_root   = CW'(signed'({1'b0, sq_chain[SQ-1].q}));

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_q <= qte_pkg::prerot(CW'(side_end.ya), c_root);
			pb_q <= qte_pkg::prerot(CW'(side_end.yb), CW'(side_end.xb));
			pc_q <= qte_pkg::prerot(CW'(side_end.yc), CW'(side_end.xc));
			ptag_q.lock      <= side_end.lock;
			ptag_q.elev_lock <= side_end.elev_lock;
		end
	end

	// three CORDIC lanes
	qte_pkg::lane_t ca [CORDIC_STAGES];
	qte_pkg::lane_t cb [CORDIC_STAGES];
	qte_pkg::lane_t cc [CORDIC_STAGES];
	qte_pkg::tag_t  ctag_q [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		if (i == 0) begin : g_first
			qte_cordic_cell #(.STAGE(i)) u_a (.clk(clk), .en(adv), .lane_i(pa_q), .lane_o(ca[i]));
			qte_cordic_cell #(.STAGE(i)) u_b (.clk(clk), .en(adv), .lane_i(pb_q), .lane_o(cb[i]));
			qte_cordic_cell #(.STAGE(i)) u_c (.clk(clk), .en(adv), .lane_i(pc_q), .lane_o(cc[i]));
			always_ff @(posedge clk) begin
				if (adv) begin
					ctag_q[i] <= ptag_q;
				end
			end
		end else begin : g_rest
			qte_cordic_cell #(.STAGE(i)) u_a (.clk(clk), .en(adv), .lane_i(ca[i-1]),
				.lane_o(ca[i]));
			qte_cordic_cell #(.STAGE(i)) u_b (.clk(clk), .en(adv), .lane_i(cb[i-1]),
				.lane_o(cb[i]));
			qte_cordic_cell #(.STAGE(i)) u_c (.clk(clk), .en(adv), .lane_i(cc[i-1]),
				.lane_o(cc[i]));
			always_ff @(posedge clk) begin
				if (adv) begin
					ctag_q[i] <= ctag_q[i-1];
				end
			end
		end
	end

	// output stage: round, saturate, remap signs
	qte_pkg::lane_t       la, lb, lc;
	qte_pkg::tag_t        tg;
	logic signed [qte_pkg::AW-1:0] ang_a, ang_b, ang_c;
	logic signed [qte_pkg::AW-1:0] neg_a, neg_b;
	logic signed [qte_pkg::ZW-1:0] za, zb, zc;

	always_comb begin
		la    = ca[CORDIC_STAGES-1];
		lb    = cb[CORDIC_STAGES-1];
		lc    = cc[CORDIC_STAGES-1];
		tg    = ctag_q[CORDIC_STAGES-1];
		za    = la.zero ? '0 : la.z;
		zb    = lb.zero ? '0 : lb.z;
		zc    = lc.zero ? '0 : lc.z;
		ang_a = qte_pkg::out_angle(za, qte_pkg::ELEV_LIM);
		ang_b = qte_pkg::out_angle(zb, qte_pkg::HEAD_LIM);
		ang_c = qte_pkg::out_angle(zc, qte_pkg::HEAD_LIM);
		neg_a = -ang_a;
		neg_b = -ang_b;
	end

	logic signed [16:0] heading_q;
	logic signed [15:0] elev_q;
	logic signed [16:0] bank_q;
	logic               lock_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= tg.lock ? 17'sd0 : ang_c[16:0];
			elev_q    <= tg.lock ? tg.elev_lock : neg_a[15:0];
			bank_q    <= neg_b[16:0];
			lock_q    <= tg.lock;
		end
	end

	assign heading_angle   = heading_q;
	assign elevation_angle = elev_q;
	assign bank_angle      = bank_q;
	assign gimbal_lock     = lock_q;

	// checks
	a_lock_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gimbal_lock) |-> (heading_angle == 17'sd0))
		else $error("heading not zero on lock word");

	a_elev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((elevation_angle <= 16'sd23040) && (elevation_angle >= -16'sd23040)))
		else $error("elevation out of range");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((heading_angle <= 17'sd46080) && (heading_angle >= -17'sd46080)
			&& (bank_angle <= 17'sd46080) && (bank_angle >= -17'sd46080)))
		else $error("heading or bank out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted word lost at entry");

endmodule
`default_nettype wire
